### src/mbet_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbet_pkg
// Shared constants for the escape-time block: field widths, register
// indexes and reset values.
// ----------------------------------------------------------------------------
package mbet_pkg;

    localparam int DEF_COORD_BITS = 12;
    localparam int DEF_ITER_BITS  = 10;
    localparam int DEF_FRAC_BITS  = 28;

    localparam int IMG_BITS       = 13;
    localparam int SPAN_BITS      = 31;
    localparam int CTR_BITS       = 32;
    localparam int MAXIT_BITS     = 10;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_ITER = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CTR_RE   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CTR_IM   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPAN_RE  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPAN_IM  = 3'd6;

    localparam int                   RST_MAX_ITER = 200;
    localparam logic [IMG_BITS-1:0]  RST_IMG      = 13'd1024;
    localparam logic [SPAN_BITS-1:0] RST_SPAN     = 31'd536870912;

endpackage

### src/mbet_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbet_div_cell
// One restoring-division step: shifts one dividend bit into the partial
// remainder, trial-subtracts the divisor and shifts the quotient bit in.
// ----------------------------------------------------------------------------
module mbet_div_cell import mbet_pkg::*; #(
    parameter int NUM_BITS = 45,
    parameter int DVS_BITS = IMG_BITS + 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_neg,
    input  logic [DVS_BITS-1:0] i_rem,
    input  logic [NUM_BITS-1:0] i_dq,
    input  logic [DVS_BITS-1:0] i_dvs,
    output logic                o_valid,
    output logic                o_neg,
    output logic [DVS_BITS-1:0] o_rem,
    output logic [NUM_BITS-1:0] o_dq
);

    logic [DVS_BITS:0]   trial;
    logic [DVS_BITS:0]   diff;
    logic                ge;
    logic [DVS_BITS-1:0] n_rem;
    logic [NUM_BITS-1:0] n_dq;
    logic                r_valid;
    logic                r_neg;
    logic [DVS_BITS-1:0] r_rem;
    logic [NUM_BITS-1:0] r_dq;

    always_comb begin
        trial = {i_rem, i_dq[NUM_BITS-1]};
        diff  = trial - {1'b0, i_dvs};
        ge    = trial >= {1'b0, i_dvs};
        n_rem = ge ? diff[DVS_BITS-1:0] : trial[DVS_BITS-1:0];
        // dividend bits leave at the top, quotient bits enter at the bottom
        n_dq  = {i_dq[NUM_BITS-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_neg <= i_neg;
        r_rem <= n_rem;
        r_dq  <= n_dq;
    end

    assign o_valid = r_valid;
    assign o_neg   = r_neg;
    assign o_rem   = r_rem;
    assign o_dq    = r_dq;

endmodule

### src/mbet_iter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbet_iter
// Forms c from the divided offsets and the view center, then runs
// z = z*z + c with saturating fixed point until escape or the limit.
// ----------------------------------------------------------------------------
module mbet_iter import mbet_pkg::*; #(
    parameter int ITER_BITS = DEF_ITER_BITS,
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    parameter int NUM_BITS  = 45
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [NUM_BITS-1:0]  i_q_re,
    input  logic                 i_neg_re,
    input  logic [NUM_BITS-1:0]  i_q_im,
    input  logic                 i_neg_im,
    input  logic [CTR_BITS-1:0]  i_ctr_re,
    input  logic [CTR_BITS-1:0]  i_ctr_im,
    input  logic [ITER_BITS-1:0] i_max_iter,
    input  logic                 i_take,
    output logic                 o_done,
    output logic [ITER_BITS-1:0] o_count
);

    localparam int V  = FRAC_BITS + 4;
    localparam int PW = 2 * V;
    localparam int MW = PW - FRAC_BITS;
    localparam int LW = ((NUM_BITS > V) ? NUM_BITS : V) + 1;
    localparam int CW = ((V > CTR_BITS) ? V : CTR_BITS) + 2;
    localparam logic signed [V-1:0] VMAX = {1'b0, {(V-1){1'b1}}};
    localparam logic signed [V-1:0] VMIN = {1'b1, {(V-1){1'b0}}};
    localparam logic [V:0]          FOUR = (V+1)'(1) << (FRAC_BITS + 2);

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOAD, ST_CTR, ST_MUL, ST_SAT, ST_UPD, ST_DONE
    } t_state;

    function automatic logic signed [V-1:0] clamp(input logic signed [CW-1:0] s);
        logic signed [V-1:0] res;
        begin
            if (s > CW'(VMAX)) res = VMAX;
            else if (s < CW'(VMIN)) res = VMIN;
            else res = V'(s);
            return res;
        end
    endfunction

    function automatic logic signed [V-1:0] off_sat(input logic [NUM_BITS-1:0] q,
                                                    input logic neg);
        logic [LW-1:0]       qe;
        logic [LW-1:0]       qn;
        logic signed [V-1:0] res;
        begin
            qe = LW'(q);
            qn = -qe;
            if (qe > LW'(VMAX)) res = neg ? VMIN : VMAX;
            else res = neg ? $signed(qn[V-1:0]) : $signed(qe[V-1:0]);
            return res;
        end
    endfunction

    function automatic logic [V-1:0] mag(input logic signed [V-1:0] a);
        logic [V-1:0] res;
        begin
            res = a[V-1] ? V'(-a) : V'(a);
            return res;
        end
    endfunction

    // product shifted down, then held to the positive limit
    function automatic logic [V-1:0] pmag(input logic [PW-1:0] p);
        logic [MW-1:0] m;
        logic [V-1:0]  res;
        begin
            m = p[PW-1:FRAC_BITS];
            if (m > MW'(VMAX)) res = VMAX;
            else res = m[V-1:0];
            return res;
        end
    endfunction

    t_state                r_state;
    logic [ITER_BITS-1:0]  r_n;
    logic [NUM_BITS-1:0]   r_q_re;
    logic [NUM_BITS-1:0]   r_q_im;
    logic                  r_neg_re;
    logic                  r_neg_im;
    logic signed [V-1:0]   r_cr;
    logic signed [V-1:0]   r_ci;
    logic signed [V-1:0]   r_zr;
    logic signed [V-1:0]   r_zi;
    logic [PW-1:0]         r_p_rr;
    logic [PW-1:0]         r_p_ii;
    logic [PW-1:0]         r_p_ri;
    logic                  r_ri_neg;
    logic signed [V-1:0]   r_rr;
    logic signed [V-1:0]   r_ii;
    logic signed [V-1:0]   r_ri;

    logic [V-1:0]          azr;
    logic [V-1:0]          azi;
    logic [V-1:0]          ri_mag;
    logic signed [V-1:0]   ri_sat;
    logic                  esc;
    logic signed [V-1:0]   n_zr;
    logic signed [V-1:0]   ri2;
    logic signed [V-1:0]   n_zi;
    logic signed [V-1:0]   cr_sum;
    logic signed [V-1:0]   ci_sum;

    always_comb begin
        azr    = mag(r_zr);
        azi    = mag(r_zi);
        ri_mag = pmag(r_p_ri);
        if (r_ri_neg) ri_sat = (r_p_ri[PW-1:FRAC_BITS] > MW'(VMAX)) ? VMIN : V'(-ri_mag);
        else ri_sat = $signed(ri_mag);
        esc    = ((V+1)'(unsigned'(r_rr)) + (V+1)'(unsigned'(r_ii))) > FOUR;
        n_zr   = clamp(CW'(r_rr) - CW'(r_ii) + CW'(r_cr));
        ri2    = clamp(CW'(r_ri) + CW'(r_ri));
        n_zi   = clamp(CW'(ri2) + CW'(r_ci));
        cr_sum = clamp(CW'(r_cr) + CW'(r_zr));
        ci_sum = clamp(CW'(r_ci) + CW'(r_zi));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_n     <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_q_re   <= i_q_re;
                        r_q_im   <= i_q_im;
                        r_neg_re <= i_neg_re;
                        r_neg_im <= i_neg_im;
                        r_n      <= '0;
                        r_state  <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    r_cr    <= off_sat(r_q_re, r_neg_re);
                    r_ci    <= off_sat(r_q_im, r_neg_im);
                    r_zr    <= clamp(CW'($signed(i_ctr_re)));
                    r_zi    <= clamp(CW'($signed(i_ctr_im)));
                    r_state <= ST_CTR;
                end
                ST_CTR: begin
                    r_cr    <= cr_sum;
                    r_ci    <= ci_sum;
                    r_zr    <= cr_sum;
                    r_zi    <= ci_sum;
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_p_rr   <= PW'(azr) * PW'(azr);
                    r_p_ii   <= PW'(azi) * PW'(azi);
                    r_p_ri   <= PW'(azr) * PW'(azi);
                    r_ri_neg <= r_zr[V-1] ^ r_zi[V-1];
                    r_state  <= (r_n >= i_max_iter) ? ST_DONE : ST_SAT;
                end
                ST_SAT: begin
                    r_rr    <= $signed(pmag(r_p_rr));
                    r_ii    <= $signed(pmag(r_p_ii));
                    r_ri    <= ri_sat;
                    r_state <= ST_UPD;
                end
                ST_UPD: begin
                    if (esc) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_zr    <= n_zr;
                        r_zi    <= n_zi;
                        r_n     <= r_n + 1'b1;
                        r_state <= ST_MUL;
                    end
                end
                ST_DONE: begin
                    if (i_take) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_done  = (r_state == ST_DONE);
    assign o_count = r_n;

endmodule

### src/mandelbrot_escape_time.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Maps a pixel to a point c and counts z = z*z + c steps until escape.
// ----------------------------------------------------------------------------
// path of a pixel: a prep register, one register per cell of the divider
// chain (44 cells by default), ST_LOAD and ST_CTR to form c, then ST_MUL,
// ST_SAT and ST_UPD for each iteration until ST_DONE
// one pixel in flight at a time; the iteration loop sets the rate
// synchronous active-low reset restores the register defaults and empties
// the datapath
module mandelbrot_escape_time import mbet_pkg::*; #(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int ITER_BITS  = DEF_ITER_BITS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [COORD_BITS-1:0]    i_pixel_x,
    input  logic [COORD_BITS-1:0]    i_pixel_y,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [ITER_BITS-1:0]     o_escape_count,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int MAG_BITS = ((COORD_BITS + 1) > IMG_BITS) ? COORD_BITS + 1 : IMG_BITS;
    localparam int NUM_BITS = MAG_BITS + SPAN_BITS;
    localparam int DVS_BITS = IMG_BITS + 1;
    localparam int MB       = (ITER_BITS < MAXIT_BITS) ? ITER_BITS : MAXIT_BITS;
    localparam logic [ITER_BITS-1:0] MAXIT_RST = ITER_BITS'(RST_MAX_ITER % (1 << ITER_BITS));

    logic [ITER_BITS-1:0]  r_max_iter;
    logic [IMG_BITS-1:0]   r_width;
    logic [IMG_BITS-1:0]   r_height;
    logic [CTR_BITS-1:0]   r_ctr_re;
    logic [CTR_BITS-1:0]   r_ctr_im;
    logic [SPAN_BITS-1:0]  r_span_re;
    logic [SPAN_BITS-1:0]  r_span_im;

    logic                  r_busy;
    logic                  r_prep_valid;
    logic [COORD_BITS-1:0] r_px;
    logic [COORD_BITS-1:0] r_py;
    logic                  r_out_valid;
    logic [ITER_BITS-1:0]  r_out_count;

    logic                  in_take;
    logic                  cfg_take;
    logic                  out_load;
    logic                  eng_done;
    logic [ITER_BITS-1:0]  eng_count;

    logic [IMG_BITS-1:0]   nn_x;
    logic [IMG_BITS-1:0]   nn_y;
    logic signed [MAG_BITS:0] d_x;
    logic signed [MAG_BITS:0] d_y;
    logic [MAG_BITS-1:0]   m_x;
    logic [MAG_BITS-1:0]   m_y;
    logic [DVS_BITS-1:0]   dvs_x;
    logic [DVS_BITS-1:0]   dvs_y;

    logic                  v_x   [0:NUM_BITS];
    logic                  v_y   [0:NUM_BITS];
    logic                  ng_x  [0:NUM_BITS];
    logic                  ng_y  [0:NUM_BITS];
    logic [DVS_BITS-1:0]   rm_x  [0:NUM_BITS];
    logic [DVS_BITS-1:0]   rm_y  [0:NUM_BITS];
    logic [NUM_BITS-1:0]   dq_x  [0:NUM_BITS];
    logic [NUM_BITS-1:0]   dq_y  [0:NUM_BITS];

    assign in_take     = i_in_valid && !r_busy;
    assign o_in_stall  = r_busy;
    assign o_cfg_ready = 1'b1;
    assign cfg_take    = i_cfg_valid;
    assign out_load    = eng_done && (!r_out_valid || !i_out_stall);

    // an image size of zero counts as one
    always_comb begin
        nn_x  = (r_width == '0) ? IMG_BITS'(1) : r_width;
        nn_y  = (r_height == '0) ? IMG_BITS'(1) : r_height;
        d_x   = $signed((MAG_BITS+1)'({r_px, 1'b0})) - $signed((MAG_BITS+1)'(nn_x));
        d_y   = $signed((MAG_BITS+1)'({r_py, 1'b0})) - $signed((MAG_BITS+1)'(nn_y));
        m_x   = d_x[MAG_BITS] ? MAG_BITS'(-d_x) : MAG_BITS'(d_x);
        m_y   = d_y[MAG_BITS] ? MAG_BITS'(-d_y) : MAG_BITS'(d_y);
        dvs_x = {nn_x, 1'b0};
        dvs_y = {nn_y, 1'b0};
    end

    // head of the divider chain: |2p - n| * span, remainder empty
    assign v_x[0]  = r_prep_valid;
    assign v_y[0]  = r_prep_valid;
    assign ng_x[0] = d_x[MAG_BITS];
    assign ng_y[0] = d_y[MAG_BITS];
    assign rm_x[0] = '0;
    assign rm_y[0] = '0;
    assign dq_x[0] = NUM_BITS'(m_x) * NUM_BITS'(r_span_re);
    assign dq_y[0] = NUM_BITS'(m_y) * NUM_BITS'(r_span_im);

    genvar k;
    generate
        for (k = 0; k < NUM_BITS; k++) begin : g_chain
            mbet_div_cell #(
                .NUM_BITS (NUM_BITS),
                .DVS_BITS (DVS_BITS)
            ) u_cell_x (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (v_x[k]),
                .i_neg   (ng_x[k]),
                .i_rem   (rm_x[k]),
                .i_dq    (dq_x[k]),
                .i_dvs   (dvs_x),
                .o_valid (v_x[k+1]),
                .o_neg   (ng_x[k+1]),
                .o_rem   (rm_x[k+1]),
                .o_dq    (dq_x[k+1])
            );
            mbet_div_cell #(
                .NUM_BITS (NUM_BITS),
                .DVS_BITS (DVS_BITS)
            ) u_cell_y (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (v_y[k]),
                .i_neg   (ng_y[k]),
                .i_rem   (rm_y[k]),
                .i_dq    (dq_y[k]),
                .i_dvs   (dvs_y),
                .o_valid (v_y[k+1]),
                .o_neg   (ng_y[k+1]),
                .o_rem   (rm_y[k+1]),
                .o_dq    (dq_y[k+1])
            );
        end
    endgenerate

    mbet_iter #(
        .ITER_BITS (ITER_BITS),
        .FRAC_BITS (FRAC_BITS),
        .NUM_BITS  (NUM_BITS)
    ) u_iter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (v_x[NUM_BITS] && v_y[NUM_BITS]),
        .i_q_re     (dq_x[NUM_BITS]),
        .i_neg_re   (ng_x[NUM_BITS]),
        .i_q_im     (dq_y[NUM_BITS]),
        .i_neg_im   (ng_y[NUM_BITS]),
        .i_ctr_re   (r_ctr_re),
        .i_ctr_im   (r_ctr_im),
        .i_max_iter (r_max_iter),
        .i_take     (out_load),
        .o_done     (eng_done),
        .o_count    (eng_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= MAXIT_RST;
            r_width    <= RST_IMG;
            r_height   <= RST_IMG;
            r_ctr_re   <= '0;
            r_ctr_im   <= '0;
            r_span_re  <= RST_SPAN;
            r_span_im  <= RST_SPAN;
        end else if (cfg_take) begin
            unique case (i_cfg_index)
                CFG_MAX_ITER: r_max_iter <= ITER_BITS'(i_cfg_data[MB-1:0]);
                CFG_WIDTH:    r_width    <= i_cfg_data[IMG_BITS-1:0];
                CFG_HEIGHT:   r_height   <= i_cfg_data[IMG_BITS-1:0];
                CFG_CTR_RE:   r_ctr_re   <= i_cfg_data[CTR_BITS-1:0];
                CFG_CTR_IM:   r_ctr_im   <= i_cfg_data[CTR_BITS-1:0];
                CFG_SPAN_RE:  r_span_re  <= i_cfg_data[SPAN_BITS-1:0];
                CFG_SPAN_IM:  r_span_im  <= i_cfg_data[SPAN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_prep_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_prep_valid <= in_take;
            if (in_take) r_busy <= 1'b1;
            else if (out_load) r_busy <= 1'b0;
            if (out_load) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
        if (in_take) begin
            r_px <= i_pixel_x;
            r_py <= i_pixel_y;
        end
        if (out_load) r_out_count <= eng_count;
    end

    assign o_out_valid    = r_out_valid;
    assign o_escape_count = r_out_count;

endmodule
